@@ design/obcs_pkg.sv @@
`default_nettype none

package obcs_pkg;

  // Slot count and packed field layout of the configuration registers
  localparam int MOTOR_SLOTS_DEF = 8;
  localparam int FIELD_SLOTS     = 8;
  localparam int CNT_W           = 4;
  localparam int ID_W            = 4;
  localparam int CODE_W          = 5;
  localparam int BUS_W           = 2;
  localparam int IDS_W           = 32;
  localparam int CODES_W         = 40;
  localparam int BUSES_W         = 16;
  localparam int CFG_DATA_W      = 40;
  localparam int CFG_ADDR_W      = 2;
  localparam int TIME_W          = 32;
  localparam int FLAGS_W         = 8;
  localparam int MOTOR_W         = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOTOR_IDS   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM_CODES = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BUS_CODES   = 2'd3;

  // Timing in milliseconds
  localparam int BLINK_MS       = 100;
  localparam int PERIOD_MS      = 2 * BLINK_MS;
  localparam int GROUP_FLOOR_MS = 1000;
  localparam int BLUE_GAP_MS    = 400;

  // Mapped codes and buses
  localparam int CODE_MAX = 16;
  localparam int BUS_MAX  = 2;

  // Width of a time offset inside a group (longest group plus margin)
  localparam int SPAN_W = 12;

  // Reciprocal for the pulse index of a short offset: e / BLINK_MS
  localparam int PHASE_SH    = 19;
  localparam int PHASE_RECIP = ((1 << PHASE_SH) + BLINK_MS - 1) / BLINK_MS;
  localparam int PHASE_PW    = SPAN_W + PHASE_SH - 6;

  localparam logic [MOTOR_W-1:0] NONE_ID = 5'd16;

endpackage

`default_nettype wire

@@ design/offline_blink_code_sequencer.sv @@
// Offline blink code sequencer.
//
// Input channel (in_valid / in_stall): one request per millisecond tick,
// carrying the time in_now_ms and one offline flag per motor slot.
// Result channel (out_valid / out_stall): one light and buzzer request per
// tick: red, green, blue, beep, the motor being signalled, its bus and code,
// and a flag for repeated motor ids.
// Configuration port (cfg_we / cfg_addr / cfg_wdata): write the slot count,
// packed ids, packed hardware codes and packed bus numbers; write only while
// no tick is in flight.
//
// Each request passes an input register and a result register: the result
// register loads from the input register whenever it is empty or the
// receiver does not stall, and one tick is taken every cycle while the receiver
// does not stall. The whole step (duplicate id check, rotating search over the
// slots, group timing) is one combinational pass between the two registers.
// While the receiver stalls, the result register holds and the input
// register fills, then in_stall rises; nothing is dropped.
// Reset clears the configuration, the group state and both valid bits.
`default_nettype none

module offline_blink_code_sequencer #(
  parameter int MOTOR_SLOTS = obcs_pkg::MOTOR_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [obcs_pkg::TIME_W-1:0]       in_now_ms,
  input  wire logic [obcs_pkg::FLAGS_W-1:0]      in_offline_flags,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_red_on,
  output logic                                   out_green_on,
  output logic                                   out_blue_on,
  output logic                                   out_beep_on,
  output logic [obcs_pkg::MOTOR_W-1:0]           out_active_motor,
  output logic [obcs_pkg::BUS_W-1:0]             out_shown_bus,
  output logic [obcs_pkg::CODE_W-1:0]            out_shown_code,
  output logic                                   out_config_bad,
  input  wire logic                              cfg_we,
  input  wire logic [obcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [obcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
  localparam int SLOT_N = 1 << SLOT_W;
  localparam int CNT_W  = obcs_pkg::CNT_W;
  localparam int TW     = obcs_pkg::TIME_W;
  localparam int SW     = obcs_pkg::SPAN_W;

  // Configuration registers
  logic [CNT_W-1:0]               motor_count_r;
  logic [obcs_pkg::IDS_W-1:0]     motor_ids_r;
  logic [obcs_pkg::CODES_W-1:0]   alarm_codes_r;
  logic [obcs_pkg::BUSES_W-1:0]   bus_codes_r;

  // Sequencer state
  logic              alarm_r, alarm_nxt;
  logic [SLOT_W-1:0] next_slot_r, next_slot_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [obcs_pkg::CODE_W-1:0] cur_code_r, cur_code_nxt;
  logic [obcs_pkg::BUS_W-1:0]  cur_bus_r, cur_bus_nxt;
  logic              sep_r, sep_nxt;
  logic [TW-1:0]     group_start_r, group_start_nxt;
  logic [TW-1:0]     sep_start_r, sep_start_nxt;
  logic [TW-1:0]     last_tick_r, last_tick_nxt;

  // Input register
  logic                          s1_valid_r;
  logic [TW-1:0]                 s1_now_r;
  logic [obcs_pkg::FLAGS_W-1:0]  s1_flags_r;

  // Result register
  logic                          out_valid_r;
  logic                          red_r, green_r, blue_r, beep_r, bad_r;
  logic [obcs_pkg::MOTOR_W-1:0]  motor_r;
  logic [obcs_pkg::BUS_W-1:0]    bus_r;
  logic [obcs_pkg::CODE_W-1:0]   code_r;

  logic advance, fire;

  // Per-slot views of the packed registers
  logic [CNT_W-1:0]             cnt;
  logic [SLOT_N-1:0]            off_vec;
  logic [obcs_pkg::ID_W-1:0]    slot_id   [SLOT_N];
  logic [obcs_pkg::CODE_W-1:0]  slot_code [SLOT_N];
  logic [obcs_pkg::BUS_W-1:0]   slot_bus  [SLOT_N];

  // Rotating search results
  logic [SLOT_W-1:0] start_slot, hi_idx, lo_idx, bg_idx, bg_next;
  logic              hi_found;
  logic [obcs_pkg::CODE_W-1:0] bg_code;
  logic [obcs_pkg::BUS_W-1:0]  bg_bus;

  // Step results
  logic bad, any_off, cur_off;
  logic sep1, do_bg;
  logic [TW-1:0] sep_start1, elapsed;
  logic [SLOT_W-1:0] slot2;
  logic [obcs_pkg::CODE_W-1:0] code2;
  logic [obcs_pkg::BUS_W-1:0]  bus2;
  logic [SW-1:0] red_dur, group_dur, beep_dur;
  logic phase_on;
  logic red_c, green_c, blue_c, beep_c;
  logic [obcs_pkg::MOTOR_W-1:0] motor_c;
  logic [obcs_pkg::BUS_W-1:0]   bus_c;
  logic [obcs_pkg::CODE_W-1:0]  code_c;

  // True in the first half of each pulse period; valid for offsets below 2^SPAN_W
  function automatic logic pulse_phase(input logic [SW-1:0] e);
    logic [obcs_pkg::PHASE_PW-1:0] prod;
    prod = obcs_pkg::PHASE_PW'(e) * obcs_pkg::PHASE_PW'(obcs_pkg::PHASE_RECIP);
    return !prod[obcs_pkg::PHASE_SH];
  endfunction

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Clamp the slot count to the configured slot capacity
  assign cnt = ({1'b0, motor_count_r} > (CNT_W + 1)'(MOTOR_SLOTS)) ?
               CNT_W'(MOTOR_SLOTS) : motor_count_r;

  for (genvar s = 0; s < SLOT_N; s++) begin : g_slot
    if (s < obcs_pkg::FIELD_SLOTS && s < MOTOR_SLOTS) begin : g_used
      logic [obcs_pkg::BUS_W-1:0] bus_raw;
      assign bus_raw      = bus_codes_r[obcs_pkg::BUS_W*s +: obcs_pkg::BUS_W];
      assign slot_id[s]   = motor_ids_r[obcs_pkg::ID_W*s +: obcs_pkg::ID_W];
      assign slot_code[s] = alarm_codes_r[obcs_pkg::CODE_W*s +: obcs_pkg::CODE_W];
      assign slot_bus[s]  = (bus_raw != '0 && bus_raw <= obcs_pkg::BUS_W'(obcs_pkg::BUS_MAX)) ?
                            bus_raw : '0;
      assign off_vec[s]   = s1_flags_r[s] && ((CNT_W + 1)'(s) < {1'b0, cnt});
    end else begin : g_pad
      // Slots past the packed fields read as zero and are never offline
      assign slot_id[s]   = '0;
      assign slot_code[s] = '0;
      assign slot_bus[s]  = '0;
      assign off_vec[s]   = 1'b0;
    end
  end

  // Repeated ids among the used slots
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < SLOT_N; i++) begin
      for (int j = i + 1; j < SLOT_N; j++) begin
        if ((CNT_W + 1)'(j) < {1'b0, cnt} && slot_id[i] == slot_id[j]) begin
          bad = 1'b1;
        end
      end
    end
  end

  assign any_off = |off_vec;
  assign cur_off = off_vec[cur_slot_r];

  // Round-robin pick: first offline slot at or after the start, else the first one
  always_comb begin
    start_slot = ((CNT_W + 1)'(next_slot_r) >= {1'b0, cnt}) ? '0 : next_slot_r;
    hi_found   = 1'b0;
    hi_idx     = '0;
    lo_idx     = '0;
    for (int s = SLOT_N - 1; s >= 0; s--) begin
      if (off_vec[s]) begin
        lo_idx = SLOT_W'(s);
        if (SLOT_W'(s) >= start_slot) begin
          hi_idx   = SLOT_W'(s);
          hi_found = 1'b1;
        end
      end
    end
  end

  assign bg_idx  = hi_found ? hi_idx : lo_idx;
  assign bg_next = ((CNT_W + 1)'(bg_idx) + (CNT_W + 1)'(1) == {1'b0, cnt}) ?
                   '0 : SLOT_W'(bg_idx + 1'b1);
  assign bg_bus  = slot_bus[bg_idx];
  // Unmapped code or bus blinks steady red
  assign bg_code = (slot_code[bg_idx] == '0 ||
                    slot_code[bg_idx] > obcs_pkg::CODE_W'(obcs_pkg::CODE_MAX) ||
                    bg_bus == '0) ? '0 : slot_code[bg_idx];

  // Separator entry: recovery of the shown motor or a late tick
  always_comb begin
    sep1       = sep_r;
    sep_start1 = sep_start_r;
    if (alarm_r && !sep_r &&
        (!cur_off || (s1_now_r - last_tick_r) >= TW'(obcs_pkg::BLINK_MS))) begin
      sep1       = 1'b1;
      sep_start1 = s1_now_r;
    end
  end

  assign do_bg   = !alarm_r ||
                   (sep1 && (s1_now_r - sep_start1) >= TW'(obcs_pkg::BLUE_GAP_MS));
  assign slot2   = do_bg ? bg_idx  : cur_slot_r;
  assign code2   = do_bg ? bg_code : cur_code_r;
  assign bus2    = do_bg ? bg_bus  : cur_bus_r;
  assign elapsed = do_bg ? '0 : s1_now_r - group_start_r;

  assign red_dur   = SW'(code2 * SW'(obcs_pkg::PERIOD_MS));
  assign beep_dur  = SW'(bus2 * SW'(obcs_pkg::PERIOD_MS));
  assign group_dur = (red_dur > SW'(obcs_pkg::GROUP_FLOOR_MS)) ?
                     red_dur : SW'(obcs_pkg::GROUP_FLOOR_MS);
  assign phase_on  = pulse_phase(elapsed[SW-1:0]);

  always_comb begin
    alarm_nxt       = alarm_r;
    next_slot_nxt   = next_slot_r;
    cur_slot_nxt    = cur_slot_r;
    cur_code_nxt    = cur_code_r;
    cur_bus_nxt     = cur_bus_r;
    sep_nxt         = sep_r;
    group_start_nxt = group_start_r;
    sep_start_nxt   = sep_start_r;
    last_tick_nxt   = last_tick_r;
    red_c           = 1'b0;
    green_c         = 1'b0;
    blue_c          = 1'b0;
    beep_c          = 1'b0;
    motor_c         = obcs_pkg::NONE_ID;
    bus_c           = '0;
    code_c          = '0;

    if (bad) begin
      // Hold all state, show red only
      red_c = 1'b1;
    end else if (!any_off) begin
      // Drop the group, show green
      green_c       = 1'b1;
      alarm_nxt     = 1'b0;
      sep_nxt       = 1'b0;
      cur_code_nxt  = '0;
      cur_bus_nxt   = '0;
      last_tick_nxt = s1_now_r;
    end else begin
      last_tick_nxt = s1_now_r;
      motor_c       = {1'b0, slot_id[slot2]};
      bus_c         = bus2;
      code_c        = code2;
      sep_nxt       = sep1;
      sep_start_nxt = sep_start1;
      if (do_bg) begin
        // Start the group of the next offline motor
        alarm_nxt       = 1'b1;
        next_slot_nxt   = bg_next;
        cur_slot_nxt    = bg_idx;
        cur_code_nxt    = bg_code;
        cur_bus_nxt     = bg_bus;
        group_start_nxt = s1_now_r;
        sep_nxt         = 1'b0;
      end
      if (sep1 && !do_bg) begin
        blue_c = 1'b1;
      end else if (elapsed >= TW'(group_dur)) begin
        // Group time is up: open the separator
        sep_nxt       = 1'b1;
        sep_start_nxt = s1_now_r;
        blue_c        = 1'b1;
      end else begin
        red_c  = (code2 == '0) || (elapsed < TW'(red_dur) && phase_on);
        beep_c = (elapsed < TW'(beep_dur)) && phase_on;
      end
    end
  end

  // Control, configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      motor_count_r <= '0;
      motor_ids_r   <= '0;
      alarm_codes_r <= '0;
      bus_codes_r   <= '0;
      alarm_r       <= 1'b0;
      next_slot_r   <= '0;
      cur_slot_r    <= '0;
      cur_code_r    <= '0;
      cur_bus_r     <= '0;
      sep_r         <= 1'b0;
      group_start_r <= '0;
      sep_start_r   <= '0;
      last_tick_r   <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          obcs_pkg::REG_MOTOR_COUNT: motor_count_r <= cfg_wdata[CNT_W-1:0];
          obcs_pkg::REG_MOTOR_IDS:   motor_ids_r   <= cfg_wdata[obcs_pkg::IDS_W-1:0];
          obcs_pkg::REG_ALARM_CODES: alarm_codes_r <= cfg_wdata[obcs_pkg::CODES_W-1:0];
          obcs_pkg::REG_BUS_CODES:   bus_codes_r   <= cfg_wdata[obcs_pkg::BUSES_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        alarm_r       <= alarm_nxt;
        next_slot_r   <= next_slot_nxt;
        cur_slot_r    <= cur_slot_nxt;
        cur_code_r    <= cur_code_nxt;
        cur_bus_r     <= cur_bus_nxt;
        sep_r         <= sep_nxt;
        group_start_r <= group_start_nxt;
        sep_start_r   <= sep_start_nxt;
        last_tick_r   <= last_tick_nxt;
      end
    end
  end

  // Payload registers: load the tick while not stalled, the result on fire
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_now_r   <= in_now_ms;
      s1_flags_r <= in_offline_flags;
    end
    if (fire) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
      beep_r  <= beep_c;
      motor_r <= motor_c;
      bus_r   <= bus_c;
      code_r  <= code_c;
      bad_r   <= bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_on       = red_r;
  assign out_green_on     = green_r;
  assign out_blue_on      = blue_r;
  assign out_beep_on      = beep_r;
  assign out_active_motor = motor_r;
  assign out_shown_bus    = bus_r;
  assign out_shown_code   = code_r;
  assign out_config_bad   = bad_r;

endmodule

`default_nettype wire

@@ design/obcs_checker.sv @@
`default_nettype none

module obcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_red_on,
  input wire logic                          out_green_on,
  input wire logic                          out_blue_on,
  input wire logic                          out_beep_on,
  input wire logic [obcs_pkg::MOTOR_W-1:0]  out_active_motor,
  input wire logic [obcs_pkg::BUS_W-1:0]    out_shown_bus,
  input wire logic [obcs_pkg::CODE_W-1:0]   out_shown_code,
  input wire logic                          out_config_bad
);

  // A stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_on) &&
      $stable(out_blue_on) && $stable(out_beep_on) && $stable(out_active_motor))
    else $error("stalled result changed");

  // At most one light color at a time
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_red_on, out_green_on, out_blue_on}))
    else $error("more than one light on");

  // Bad config shows red only and no motor
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_bad |-> out_red_on && !out_beep_on &&
      out_active_motor == obcs_pkg::NONE_ID && out_shown_code == '0)
    else $error("bad config result not red only");

  // Green means no motor is signalled
  a_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_green_on |-> !out_beep_on && out_shown_bus == '0 &&
      out_shown_code == '0 && out_active_motor == obcs_pkg::NONE_ID)
    else $error("green with a motor shown");

  // A beep needs a mapped bus
  a_beep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep_on |-> out_shown_bus != '0 && !out_green_on)
    else $error("beep without a bus");

endmodule

bind offline_blink_code_sequencer obcs_checker u_obcs_checker (.*);

`default_nettype wire

@@ tb/tb_offline_blink_code_sequencer.sv @@
`default_nettype none

typedef logic [obcs_pkg::TIME_W-1:0] ms_t;

typedef struct packed {
  logic                         red;
  logic                         green;
  logic                         blue;
  logic                         beep;
  logic [obcs_pkg::MOTOR_W-1:0] motor;
  logic [obcs_pkg::BUS_W-1:0]   bus;
  logic [obcs_pkg::CODE_W-1:0]  code;
  logic                         bad;
} lamp_t;

// Tracks the blink sequencer: a private copy of the registers and the group
// state, and the lamp settings still owed by the block, oldest first.
class lamp_board;
  logic [obcs_pkg::CNT_W-1:0]   slot_count;
  logic [obcs_pkg::IDS_W-1:0]   ids;
  logic [obcs_pkg::CODES_W-1:0] codes;
  logic [obcs_pkg::BUSES_W-1:0] buses;

  bit                          alarm_on;
  bit                          sep_on;
  int unsigned                 next_idx;
  int unsigned                 cur_idx;
  logic [obcs_pkg::CODE_W-1:0] cur_code;
  logic [obcs_pkg::BUS_W-1:0]  cur_bus;
  ms_t                         group_t0;
  ms_t                         sep_t0;
  ms_t                         last_tick;

  lamp_t owed_q[$];
  int    mismatches;

  function new();
    slot_count = '0;
    ids        = '0;
    codes      = '0;
    buses      = '0;
    alarm_on   = 0;
    sep_on     = 0;
    next_idx   = 0;
    cur_idx    = 0;
    cur_code   = '0;
    cur_bus    = '0;
    group_t0   = '0;
    sep_t0     = '0;
    last_tick  = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [obcs_pkg::CFG_ADDR_W-1:0] addr,
                          logic [obcs_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      obcs_pkg::REG_MOTOR_COUNT: slot_count = data[obcs_pkg::CNT_W-1:0];
      obcs_pkg::REG_MOTOR_IDS:   ids        = data[obcs_pkg::IDS_W-1:0];
      obcs_pkg::REG_ALARM_CODES: codes      = data[obcs_pkg::CODES_W-1:0];
      obcs_pkg::REG_BUS_CODES:   buses      = data[obcs_pkg::BUSES_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned slots_in_use();
    return (slot_count > obcs_pkg::MOTOR_SLOTS_DEF) ? obcs_pkg::MOTOR_SLOTS_DEF : slot_count;
  endfunction

  function bit is_offline(int unsigned idx, logic [obcs_pkg::FLAGS_W-1:0] flags);
    return idx < slots_in_use() && flags[idx];
  endfunction

  // Round-robin search for the next offline slot, starting after the last one shown.
  function void open_group(ms_t now, logic [obcs_pkg::FLAGS_W-1:0] flags);
    int unsigned                 cnt;
    int unsigned                 idx;
    logic [obcs_pkg::CODE_W-1:0] code;
    logic [obcs_pkg::BUS_W-1:0]  raw_bus;
    cnt = slots_in_use();
    if (cnt == 0) return;
    if (next_idx >= cnt) next_idx = 0;
    for (int n = 0; n < cnt; n++) begin
      idx      = next_idx;
      next_idx = (idx + 1) % cnt;
      if (is_offline(idx, flags)) begin
        code     = codes[idx*obcs_pkg::CODE_W +: obcs_pkg::CODE_W];
        raw_bus  = buses[idx*obcs_pkg::BUS_W +: obcs_pkg::BUS_W];
        cur_idx  = idx;
        cur_bus  = (raw_bus == 1 || raw_bus == 2) ? raw_bus : '0;
        cur_code = (code == 0 || code > obcs_pkg::CODE_MAX || cur_bus == 0) ? '0 : code;
        sep_on   = 0;
        group_t0 = now;
        alarm_on = 1;
        return;
      end
    end
  endfunction

  function lamp_t step_lamps(ms_t now, logic [obcs_pkg::FLAGS_W-1:0] flags);
    lamp_t                     r;
    logic [15:0]               seen;
    logic [obcs_pkg::ID_W-1:0] id;
    bit                        dup;
    bit                        any_off;
    bit                        shown;
    ms_t                       gap;
    ms_t                       elapsed;
    ms_t                       red_dur;
    ms_t                       dur;
    seen    = '0;
    dup     = 0;
    any_off = 0;
    for (int i = 0; i < slots_in_use(); i++) begin
      id = ids[i*obcs_pkg::ID_W +: obcs_pkg::ID_W];
      if (seen[id]) dup = 1;
      seen[id] = 1'b1;
      if (is_offline(i, flags)) any_off = 1;
    end
    r       = '0;
    r.motor = obcs_pkg::NONE_ID;
    r.bad   = dup;
    // repeated ids: red only, state frozen
    if (dup) begin
      r.red = 1'b1;
      return r;
    end
    if (!any_off) begin
      alarm_on  = 0;
      sep_on    = 0;
      cur_code  = '0;
      cur_bus   = '0;
      last_tick = now;
      r.green   = 1'b1;
      return r;
    end
    gap = now - last_tick;
    if (!alarm_on) begin
      open_group(now, flags);
    end else if (!sep_on && (!is_offline(cur_idx, flags) || gap >= obcs_pkg::BLINK_MS)) begin
      // recovered motor or late tick cuts the group short
      sep_on = 1;
      sep_t0 = now;
    end
    last_tick = now;
    shown     = 0;
    if (sep_on) begin
      if (ms_t'(now - sep_t0) < obcs_pkg::BLUE_GAP_MS) begin
        r.blue = 1'b1;
        shown  = 1;
      end else begin
        open_group(now, flags);
      end
    end
    if (!shown) begin
      elapsed = now - group_t0;
      red_dur = obcs_pkg::PERIOD_MS * cur_code;
      dur     = (red_dur > obcs_pkg::GROUP_FLOOR_MS) ? red_dur : obcs_pkg::GROUP_FLOOR_MS;
      if (elapsed >= dur) begin
        sep_on = 1;
        sep_t0 = now;
        r.blue = 1'b1;
      end else begin
        r.red  = cur_code == 0 ||
                 (elapsed < red_dur && elapsed % obcs_pkg::PERIOD_MS < obcs_pkg::BLINK_MS);
        r.beep = elapsed < obcs_pkg::PERIOD_MS * cur_bus &&
                 elapsed % obcs_pkg::PERIOD_MS < obcs_pkg::BLINK_MS;
      end
    end
    r.motor = {1'b0, ids[cur_idx*obcs_pkg::ID_W +: obcs_pkg::ID_W]};
    r.bus   = cur_bus;
    r.code  = cur_code;
    return r;
  endfunction

  function void note_tick(ms_t now, logic [obcs_pkg::FLAGS_W-1:0] flags);
    owed_q.push_back(step_lamps(now, flags));
  endfunction

  function string lamp_text(lamp_t l);
    return $sformatf("red %b green %b blue %b beep %b motor %0d bus %0d code %0d bad %b",
                     l.red, l.green, l.blue, l.beep, l.motor, l.bus, l.code, l.bad);
  endfunction

  function void check_lamps(lamp_t got);
    lamp_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected lamp request: %s", $time, lamp_text(got));
      return;
    end
    want = owed_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: lamp mismatch", $time);
        $display("  expected %s", lamp_text(want));
        $display("  actual   %s", lamp_text(got));
      end
    end
  endfunction

  function int unsigned outstanding();
    return owed_q.size();
  endfunction
endclass

module tb_offline_blink_code_sequencer;

  // Results pass the input and result registers; DRAIN_CYCLES of idle wait cover slack.
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 150;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [obcs_pkg::TIME_W-1:0]     in_now_ms = '0;
  logic [obcs_pkg::FLAGS_W-1:0]    in_offline_flags = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_red_on;
  logic                            out_green_on;
  logic                            out_blue_on;
  logic                            out_beep_on;
  logic [obcs_pkg::MOTOR_W-1:0]    out_active_motor;
  logic [obcs_pkg::BUS_W-1:0]      out_shown_bus;
  logic [obcs_pkg::CODE_W-1:0]     out_shown_code;
  logic                            out_config_bad;
  logic                            cfg_we = 1'b0;
  logic [obcs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [obcs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  lamp_board sb;
  lamp_t     lamps_out;
  int        lamps_taken = 0;

  // running time and offline pattern of the random part
  ms_t          clock_ms;
  logic [7:0]   live_flags;

  offline_blink_code_sequencer dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign lamps_out = {out_red_on, out_green_on, out_blue_on, out_beep_on,
                      out_active_motor, out_shown_bus, out_shown_code, out_config_bad};

  // Compare every request that leaves the block against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_lamps(lamps_out);
      lamps_taken++;
    end
  end

  // Receiver: random stalls, calm stretches, long stalls, and one long
  // hold-off that fills the pipeline and pushes back on the sender.
  initial begin : receiver
    int  hold_left;
    int  burst_left;
    int  calm_left;
    bit  pressure_done;
    hold_left     = 0;
    burst_left    = 0;
    calm_left     = 0;
    pressure_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!pressure_done && lamps_taken >= 250) begin
        pressure_done = 1;
        hold_left     = HOLD_OFF_CYCLES;
        out_stall    <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            calm_left  = $urandom_range(20, 80);
            out_stall <= 1'b0;
          end
          1: begin
            burst_left = $urandom_range(8, 40);
            out_stall <= 1'b1;
          end
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one tick request and hold it until the block takes it.
  task automatic offer_tick(input ms_t now, input logic [obcs_pkg::FLAGS_W-1:0] flags);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_now_ms        <= now;
    in_offline_flags <= flags;
    do @(posedge clk); while (in_stall);
    sb.note_tick(now, flags);
  endtask

  task automatic rest_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and wait until every owed request has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic poke_reg(input logic [obcs_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [obcs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic load_setup(input logic [obcs_pkg::CNT_W-1:0] cnt,
                            input logic [obcs_pkg::IDS_W-1:0] ids,
                            input logic [obcs_pkg::CODES_W-1:0] codes,
                            input logic [obcs_pkg::BUSES_W-1:0] buses);
    poke_reg(obcs_pkg::REG_MOTOR_COUNT, obcs_pkg::CFG_DATA_W'(cnt));
    poke_reg(obcs_pkg::REG_MOTOR_IDS, obcs_pkg::CFG_DATA_W'(ids));
    poke_reg(obcs_pkg::REG_ALARM_CODES, obcs_pkg::CFG_DATA_W'(codes));
    poke_reg(obcs_pkg::REG_BUS_CODES, obcs_pkg::CFG_DATA_W'(buses));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Phase setups: a few fixed corners first, then random motor tables.
  task automatic pick_setup(input int phase);
    logic [3:0]                   pool [16];
    logic [3:0]                   swap;
    int                           j;
    int                           k;
    logic [obcs_pkg::CNT_W-1:0]   cnt;
    logic [obcs_pkg::IDS_W-1:0]   ids;
    logic [obcs_pkg::CODES_W-1:0] codes;
    logic [obcs_pkg::BUSES_W-1:0] buses;
    for (int i = 0; i < 16; i++) pool[i] = 4'(i);
    for (int i = 15; i > 0; i--) begin
      j       = $urandom_range(0, i);
      swap    = pool[i];
      pool[i] = pool[j];
      pool[j] = swap;
    end
    for (int i = 0; i < 8; i++) begin
      ids[i*obcs_pkg::ID_W +: obcs_pkg::ID_W] = pool[i];
      codes[i*obcs_pkg::CODE_W +: obcs_pkg::CODE_W] =
        obcs_pkg::CODE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16));
      buses[i*obcs_pkg::BUS_W +: obcs_pkg::BUS_W] =
        obcs_pkg::BUS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(1, 2));
    end
    cnt = obcs_pkg::CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(2, 8));
    case (phase)
      0: cnt = 4'd15;                 // clamps to eight slots
      1: begin                        // every code and bus unmapped
        cnt   = 4'd8;
        codes = '1;
        buses = '1;
      end
      2: begin                        // no slots in use
        cnt   = 4'd0;
        ids   = '1;
        codes = '1;
        buses = '1;
      end
      3: begin                        // all ids equal
        cnt = 4'd8;
        ids = '1;
      end
      4: begin                        // single slot, all fields zero
        cnt   = 4'd1;
        ids   = '0;
        codes = '0;
        buses = '0;
      end
      default: begin
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(1, 7);
          k = $urandom_range(0, j - 1);
          ids[j*obcs_pkg::ID_W +: obcs_pkg::ID_W] = ids[k*obcs_pkg::ID_W +: obcs_pkg::ID_W];
        end
        if ($urandom_range(0, 5) == 0) codes = obcs_pkg::CODES_W'({$urandom, $urandom});
      end
    endcase
    load_setup(cnt, ids, codes, buses);
  endtask

  // Ticks mostly under a pulse apart so groups run their course; now and
  // then a late tick, a huge jump or a change of the offline pattern.
  task automatic run_phase(input int items);
    bit steady;
    int pick;
    steady     = 0;
    clock_ms   = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
                                             : $urandom;
    live_flags = 8'($urandom_range(0, 255));
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 199);
      if (pick < 2)      clock_ms += $urandom;
      else if (pick < 7) clock_ms += $urandom_range(100, 700);
      else               clock_ms += $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 3))
          0:       live_flags = '0;
          1:       live_flags = 8'($urandom_range(0, 255));
          default: live_flags ^= 8'(1 << $urandom_range(0, 7));
        endcase
      end
      offer_tick(clock_ms, live_flags);
      if ($urandom_range(0, 39) == 0) steady = !steady;
      if (!steady && $urandom_range(0, 2) == 0)
        rest_sender(($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setup: no slots in use, so green
    offer_tick(32'd0, 8'hFF);
    settle();

    // four slots: code 3 on bus 1, code 16 on bus 2, unmapped code,
    // unmapped bus
    load_setup(4'd4, {16'hFFFF, 4'd15, 4'd9, 4'd5, 4'd3},
               {20'd0, 5'd17, 5'd0, 5'd16, 5'd3},
               {8'd0, 2'd3, 2'd2, 2'd2, 2'd1});
    offer_tick(32'd1000, 8'h00);      // nothing offline
    offer_tick(32'd1000, 8'h01);      // group opens on slot 0
    offer_tick(32'd1050, 8'h01);
    offer_tick(32'd1120, 8'h01);      // pulse gap
    offer_tick(32'd1150, 8'h01);
    offer_tick(32'd1250, 8'h01);      // second pulse, no beep
    offer_tick(32'd1340, 8'h01);
    offer_tick(32'd1430, 8'h01);
    offer_tick(32'd1550, 8'h01);      // late tick cuts the group
    offer_tick(32'd2049, 8'h0E);      // separator over, slot 1 next
    offer_tick(32'd2100, 8'h0E);
    offer_tick(32'd2180, 8'h0E);
    offer_tick(32'd2200, 8'h0C);      // slot 1 recovers
    offer_tick(32'd2650, 8'h0C);      // steady red on slot 2
    offer_tick(32'd2700, 8'h08);      // slot 2 recovers
    offer_tick(32'd3100, 8'h08);      // slot 3, bus unmapped
    offer_tick(32'hFFFF_FFF0, 8'hFF); // far jump, all flags
    offer_tick(32'h0000_0030, 8'hFF); // time wraps
    offer_tick(32'hFFFF_FFFF, 8'h00);
    settle();

    for (int p = 0; p < 14; p++) begin
      pick_setup(p);
      run_phase((p == 2 || p == 3) ? 40 : ((p < 5) ? 150 : 125));
      settle();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the handshake hangs.
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
